// ===== rtl/core/sdse_pkg.sv =====
// shared types, constants and arithmetic helpers for the stick deadzone/slew block
// no dependencies; used by the interfaces and every module in rtl/core
package sdse_pkg;

   // value format and register widths
   localparam int VALUE_BITS     = 16;
   localparam int DEAD_ZONE_BITS = 15;
   localparam int MAX_STEP_BITS  = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int COMMAND_BITS   = 2;

   // headroom for slew sums and magnitude compares
   localparam int WIDE_BITS =
      ((VALUE_BITS > MAX_STEP_BITS) ? VALUE_BITS : MAX_STEP_BITS) + 2;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // full scale and diagonal magnitude (1/sqrt2 of full scale)
   localparam longint UNIT_WIDE = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
   localparam value_type UNIT = VALUE_BITS'(UNIT_WIDE);
   localparam value_type DIAG = VALUE_BITS'((UNIT_WIDE * 23170) / 32767);

   // command codes
   localparam logic [COMMAND_BITS-1:0] CMD_DIGITAL = 2'd0;
   localparam logic [COMMAND_BITS-1:0] CMD_ANALOG  = 2'd1;
   localparam logic [COMMAND_BITS-1:0] CMD_TICK    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEAD_ZONE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STEP  = 1'b1;

   localparam logic [DEAD_ZONE_BITS-1:0] DEAD_ZONE_RESET = 15'd4096;
   localparam logic [MAX_STEP_BITS-1:0]  MAX_STEP_RESET  = 16'd2048;

   // one input word as held in the input register
   typedef struct packed {
      logic [COMMAND_BITS-1:0] command;
      logic                    left_pressed;
      logic                    right_pressed;
      logic                    up_pressed;
      logic                    down_pressed;
      value_type               axis_x;
      value_type               axis_y;
   } item_type;

   // zero an axis whose magnitude is under the dead zone
   function automatic value_type dead_zoned(value_type v, logic [DEAD_ZONE_BITS-1:0] zone);
      logic signed [WIDE_BITS-1:0] ext;
      logic [WIDE_BITS-1:0]        mag;
      ext = WIDE_BITS'(v);
      mag = (v < 0) ? WIDE_BITS'(-ext) : WIDE_BITS'(ext);
      return (mag < WIDE_BITS'(zone)) ? '0 : v;
   endfunction

   // move cur toward tgt by at most step, never past it
   function automatic value_type slew(value_type cur, value_type tgt,
                                      logic [MAX_STEP_BITS-1:0] step);
      logic signed [WIDE_BITS-1:0] c;
      logic signed [WIDE_BITS-1:0] t;
      logic signed [WIDE_BITS-1:0] s;
      logic signed [WIDE_BITS-1:0] up;
      logic signed [WIDE_BITS-1:0] dn;
      logic signed [WIDE_BITS-1:0] r;
      c  = WIDE_BITS'(cur);
      t  = WIDE_BITS'(tgt);
      s  = WIDE_BITS'(step);
      up = c + s;
      dn = c - s;
      if (c < t) begin
         r = (up >= t) ? t : up;
      end else if (c > t) begin
         r = (dn <= t) ? t : dn;
      end else begin
         r = c;
      end
      return VALUE_BITS'(r);
   endfunction

endpackage

// ===== rtl/core/sdse_if.sv =====
// valid/ready channel interfaces for request and response words
// depends on sdse_pkg
interface sdse_req_if;
   logic                              valid;
   logic                              ready;
   logic [sdse_pkg::COMMAND_BITS-1:0] command;
   logic                              left_pressed;
   logic                              right_pressed;
   logic                              up_pressed;
   logic                              down_pressed;
   sdse_pkg::value_type               axis_x;
   sdse_pkg::value_type               axis_y;

   modport source (output valid, command, left_pressed, right_pressed, up_pressed,
                   down_pressed, axis_x, axis_y, input ready);
   modport sink   (input valid, command, left_pressed, right_pressed, up_pressed,
                   down_pressed, axis_x, axis_y, output ready);
endinterface

interface sdse_rsp_if;
   logic                valid;
   logic                ready;
   logic                start_event;
   logic                change_event;
   logic                end_event;
   sdse_pkg::value_type value_x;
   sdse_pkg::value_type value_y;

   modport source (output valid, start_event, change_event, end_event, value_x, value_y,
                   input ready);
   modport sink   (input valid, start_event, change_event, end_event, value_x, value_y,
                   output ready);
endinterface

// ===== rtl/core/sdse_in_stage.sv =====
// input register stage: captures one request word and holds it until taken
// depends on sdse_pkg and sdse_req_if
module sdse_in_stage (
   input  logic               clock,
   input  logic               reset,
   sdse_req_if.sink           req,
   input  logic               out_free,
   output logic               item_valid,
   output sdse_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   sdse_pkg::item_type item_ff;
   logic               take;

   // the held word moves on whenever the result register can take its outcome
   assign take      = valid_ff && out_free;
   assign req.ready = !valid_ff || out_free;

   always_comb begin
      if (req.valid && req.ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.command       <= req.command;
         item_ff.left_pressed  <= req.left_pressed;
         item_ff.right_pressed <= req.right_pressed;
         item_ff.up_pressed    <= req.up_pressed;
         item_ff.down_pressed  <= req.down_pressed;
         item_ff.axis_x        <= req.axis_x;
         item_ff.axis_y        <= req.axis_y;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/sdse_update.sv =====
// state update and result register: digital vectors, slew, deadzone, events
// depends on sdse_pkg and sdse_rsp_if
module sdse_update (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  sdse_pkg::item_type                    item,
   input  logic                                  csr_write_enable,
   input  logic [sdse_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sdse_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output logic                                  out_free,
   sdse_rsp_if.source                            rsp
);

   // configuration
   logic [sdse_pkg::DEAD_ZONE_BITS-1:0] dead_zone_ff;
   logic [sdse_pkg::MAX_STEP_BITS-1:0]  max_step_ff;

   // block state
   sdse_pkg::value_type slewed_x_ff,   slewed_x_in;
   sdse_pkg::value_type slewed_y_ff,   slewed_y_in;
   sdse_pkg::value_type target_x_ff,   target_x_in;
   sdse_pkg::value_type target_y_ff,   target_y_in;
   sdse_pkg::value_type reported_x_ff, reported_x_in;
   sdse_pkg::value_type reported_y_ff, reported_y_in;
   logic                digital_held_ff, digital_held_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                start_ff, change_ff, end_ff;
   sdse_pkg::value_type value_x_ff, value_y_ff;

   logic                take;
   logic                emit;
   logic                emit_start;
   logic                emit_end;
   sdse_pkg::value_type emit_x;
   sdse_pkg::value_type emit_y;

   // digital vector
   sdse_pkg::value_type mag;
   sdse_pkg::value_type vx;
   sdse_pkg::value_type vy;
   logic                x_on, y_on;
   logic                vzero, rzero;

   // tick path
   sdse_pkg::value_type nx, ny, ox, oy, dx, dy;
   logic                same_dz;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign take     = item_valid && out_free;

   // unit vector from the four keys; opposite keys cancel
   always_comb begin
      x_on  = item.right_pressed ^ item.left_pressed;
      y_on  = item.up_pressed ^ item.down_pressed;
      mag   = (x_on && y_on) ? sdse_pkg::DIAG : sdse_pkg::UNIT;
      vx    = !x_on ? '0 : (item.right_pressed ? mag : -mag);
      vy    = !y_on ? '0 : (item.up_pressed ? mag : -mag);
      vzero = !x_on && !y_on;
      rzero = (reported_x_ff == '0) && (reported_y_ff == '0);
   end

   // slew step and deadzone compare
   always_comb begin
      nx      = sdse_pkg::slew(slewed_x_ff, target_x_ff, max_step_ff);
      ny      = sdse_pkg::slew(slewed_y_ff, target_y_ff, max_step_ff);
      ox      = sdse_pkg::dead_zoned(reported_x_ff, dead_zone_ff);
      oy      = sdse_pkg::dead_zoned(reported_y_ff, dead_zone_ff);
      dx      = sdse_pkg::dead_zoned(nx, dead_zone_ff);
      dy      = sdse_pkg::dead_zoned(ny, dead_zone_ff);
      same_dz = (ox == dx) && (oy == dy);
   end

   // next state and result per command
   always_comb begin
      slewed_x_in     = slewed_x_ff;
      slewed_y_in     = slewed_y_ff;
      target_x_in     = target_x_ff;
      target_y_in     = target_y_ff;
      reported_x_in   = reported_x_ff;
      reported_y_in   = reported_y_ff;
      digital_held_in = digital_held_ff;
      emit            = 1'b0;
      emit_start      = 1'b0;
      emit_end        = 1'b0;
      emit_x          = vx;
      emit_y          = vy;
      if (take) begin
         case (item.command)
            sdse_pkg::CMD_DIGITAL: begin
               if (vzero && rzero) begin
                  digital_held_in = 1'b0;
               end else if (vzero || rzero || vx != reported_x_ff || vy != reported_y_ff) begin
                  digital_held_in = !vzero;
                  reported_x_in   = vx;
                  reported_y_in   = vy;
                  emit            = 1'b1;
                  emit_start      = rzero && !vzero;
                  emit_end        = vzero;
               end
            end
            sdse_pkg::CMD_ANALOG: begin
               target_x_in = item.axis_x;
               target_y_in = item.axis_y;
            end
            sdse_pkg::CMD_TICK: begin
               // a changed deadzoned value stalls while a key is held
               if (same_dz || !digital_held_ff) begin
                  slewed_x_in   = nx;
                  slewed_y_in   = ny;
                  reported_x_in = nx;
                  reported_y_in = ny;
               end
               if (!same_dz && !digital_held_ff) begin
                  emit       = 1'b1;
                  emit_end   = (dx == '0) && (dy == '0);
                  emit_start = !emit_end && (ox == '0) && (oy == '0);
                  emit_x     = dx;
                  emit_y     = dy;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff    <= sdse_pkg::DEAD_ZONE_RESET;
         max_step_ff     <= sdse_pkg::MAX_STEP_RESET;
         slewed_x_ff     <= '0;
         slewed_y_ff     <= '0;
         target_x_ff     <= '0;
         target_y_ff     <= '0;
         reported_x_ff   <= '0;
         reported_y_ff   <= '0;
         digital_held_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               sdse_pkg::CSR_DEAD_ZONE:
                  dead_zone_ff <= csr_write_data[sdse_pkg::DEAD_ZONE_BITS-1:0];
               sdse_pkg::CSR_MAX_STEP:
                  max_step_ff <= csr_write_data[sdse_pkg::MAX_STEP_BITS-1:0];
               default: begin
               end
            endcase
         end
         slewed_x_ff     <= slewed_x_in;
         slewed_y_ff     <= slewed_y_in;
         target_x_ff     <= target_x_in;
         target_y_ff     <= target_y_in;
         reported_x_ff   <= reported_x_in;
         reported_y_ff   <= reported_y_in;
         digital_held_ff <= digital_held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && emit) begin
         start_ff   <= emit_start;
         change_ff  <= 1'b1;
         end_ff     <= emit_end;
         value_x_ff <= emit_x;
         value_y_ff <= emit_y;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.start_event  = start_ff;
   assign rsp.change_event = change_ff;
   assign rsp.end_event    = end_ff;
   assign rsp.value_x      = value_x_ff;
   assign rsp.value_y      = value_y_ff;

endmodule

// ===== rtl/core/stick_deadzone_slew_events.sv =====
// top level of the two-axis stick conditioner: input register plus update stage
// depends on sdse_pkg, sdse_req_if/sdse_rsp_if, sdse_in_stage and sdse_update
//
// Takes one request word per clock while responses are taken: digital key
// updates, analog stick samples and ticks. Each word is held in the input
// register and its result, if any, is loaded into the response register once
// that register is free, so throughput is one word per cycle while responses
// are taken. A single compare/add/clamp pass lies between the input register
// and the response register. Digital and tick words produce at most one
// response, analog sample words produce none and many words produce none; a
// stalled response backs up into the input register and then into req ready.
// The user must write dead_zone (index 0) and max_step (index 1) through the csr
// port only while the block is idle; the block itself does not enforce this.
module stick_deadzone_slew_events (
   input  logic                                clock,
   input  logic                                reset,
   sdse_req_if.sink                            req_bus,
   sdse_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [sdse_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sdse_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   logic               item_valid;
   sdse_pkg::item_type item;
   logic               out_free;

   sdse_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   sdse_update u_update (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .out_free         (out_free),
      .rsp              (rsp_bus)
   );

   // an end event always reports a change and the zero vector
   a_end_is_zero_change: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.end_event |->
         rsp_bus.change_event && rsp_bus.value_x == '0 && rsp_bus.value_y == '0)
      else $error("end event without change or with nonzero value");

   // start and end never come together
   a_start_end_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.start_event && rsp_bus.end_event))
      else $error("start and end event in one word");

   // a held word behind a stalled response blocks new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      item_valid && rsp_bus.valid && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request accepted while pipeline is full");

   // no response right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

endmodule
